// ===== rtl/core/gap_buffer_text_store_core_defines.svh =====
// Assertion macros shared by the gap buffer RTL
`ifndef GAP_BUFFER_TEXT_STORE_CORE_DEFINES_SVH
`define GAP_BUFFER_TEXT_STORE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define GBTS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gap buffer check failed");

// Next-cycle implication, checked outside reset
`define GBTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gap buffer check failed");

`endif

// ===== rtl/core/gbts_pkg.sv =====
// Types and codes for the gap buffer text store
package gbts_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MOVE
    } t_state;

    localparam logic [2:0] FN_INSERT     = 3'd0;
    localparam logic [2:0] FN_DEL_BACK   = 3'd1;
    localparam logic [2:0] FN_DEL_FWD    = 3'd2;
    localparam logic [2:0] FN_MOVE_LEFT  = 3'd3;
    localparam logic [2:0] FN_MOVE_RIGHT = 3'd4;
    localparam logic [2:0] FN_READ       = 3'd5;

    localparam logic [1:0] ST_DONE       = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_NO_DELETE  = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

endpackage

// ===== rtl/core/gap_buffer_text_store_core.sv =====
// Gap buffer text store: control, cursor and length registers, text RAM
//
// One input channel (i_valid / o_stall) takes an operation word: func, a byte
// to insert, a move count and a read position. One output channel
// (o_valid / i_stall) returns one result word per operation: status, cursor,
// text length and the byte read.
// The text sits in one RAM of DEPTH bytes with a registered read;
// text before the cursor is at the bottom, text after it at the top.
// Insert, deletes, refused or out-of-range requests and moves that go nowhere
// load the result on accept; a read loads it from the RAM in ST_READ, and a
// move carries the bytes across the gap in ST_MOVE, then loads it. The move
// copy is pipelined through the RAM (read one byte, write the previous one),
// so it runs at one byte per cycle.
// One operation is in flight at a time. A new word is taken once the block is
// idle and the result register is empty or being emptied in that cycle.
// While the receiver stalls, the result word holds and no new word is taken.
// Reset (synchronous, active low) empties the text and puts the cursor at 0;
// the RAM itself is not cleared, no byte is ever read before it is written.
`include "gap_buffer_text_store_core_defines.svh"

module gap_buffer_text_store_core #(
    parameter int DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_char_in,
    input  logic [11:0] i_move_count,
    input  logic [11:0] i_read_position,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_cursor_out,
    output logic [11:0] o_text_length,
    output logic [7:0]  o_char_out
);

    localparam int AW = $clog2(DEPTH);
    localparam int XW = ((AW > 12) ? AW : 12) + 1;

    gbts_pkg::t_state r_state, n_state;

    logic [AW-1:0] r_cursor, n_cursor;
    logic [AW-1:0] r_length, n_length;

    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [11:0]   r_ocursor;
    logic [11:0]   r_olength;
    logic [7:0]    r_ochar;

    logic          r_dir_left;
    logic [AW-1:0] r_remain;
    logic [AW-1:0] r_rd_ptr;
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_target;
    logic          r_pend;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [7:0]    ram_wr_data;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;

    logic          in_acc;
    logic          go_move;
    logic          go_read;
    logic          move_issue;
    logic          ld_out;
    logic [1:0]    ld_status;
    logic [7:0]    ld_char;

    logic [XW-1:0] cur_x, len_x, cnt_x, pos_x, depth_x, gap_x, tail_x;
    logic [XW-1:0] left_nc_x, right_nc_x, read_addr_x;
    logic [XW-1:0] cur_dec_x, tail_dec_x, left_steps_x, right_steps_x;
    logic [XW-1:0] ncur_x, nlen_x;
    logic          full;

    // Wide views of the state and request fields
    assign cur_x   = {{(XW-AW){1'b0}}, r_cursor};
    assign len_x   = {{(XW-AW){1'b0}}, r_length};
    assign cnt_x   = {{(XW-12){1'b0}}, i_move_count};
    assign pos_x   = {{(XW-12){1'b0}}, i_read_position};
    assign depth_x = XW'(DEPTH);
    assign gap_x   = depth_x - len_x;
    assign tail_x  = gap_x + cur_x;
    assign full    = (len_x + XW'(1)) >= depth_x;

    assign left_nc_x   = (cnt_x >= cur_x) ? '0 : (cur_x - cnt_x);
    assign right_nc_x  = ((cur_x + cnt_x) >= len_x) ? len_x : (cur_x + cnt_x);
    assign read_addr_x = (pos_x < cur_x) ? pos_x : (pos_x + gap_x);

    assign cur_dec_x     = cur_x - XW'(1);
    assign tail_dec_x    = tail_x - XW'(1);
    assign left_steps_x  = cur_x - left_nc_x;
    assign right_steps_x = right_nc_x - cur_x;

    assign o_stall = !((r_state == gbts_pkg::ST_IDLE) && (!r_ovalid || !i_stall));
    assign in_acc  = i_valid && !o_stall;

    assign go_move = in_acc
        && (((i_func == gbts_pkg::FN_MOVE_LEFT) && (left_nc_x != cur_x))
        ||  ((i_func == gbts_pkg::FN_MOVE_RIGHT) && (right_nc_x != cur_x)));
    assign go_read = in_acc && (i_func == gbts_pkg::FN_READ) && (pos_x < len_x);

    assign move_issue = (r_state == gbts_pkg::ST_MOVE) && (r_remain != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gbts_pkg::ST_IDLE: begin
                if (go_move) begin
                    n_state = gbts_pkg::ST_MOVE;
                end else if (go_read) begin
                    n_state = gbts_pkg::ST_READ;
                end
            end
            gbts_pkg::ST_READ: begin
                n_state = gbts_pkg::ST_IDLE;
            end
            gbts_pkg::ST_MOVE: begin
                if (r_remain == '0) begin
                    n_state = gbts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = gbts_pkg::ST_IDLE;
            end
        endcase
    end

    // RAM ports, cursor and length update, result load
    always_comb begin
        n_cursor    = r_cursor;
        n_length    = r_length;
        ram_wr_en   = 1'b0;
        ram_wr_addr = r_wr_ptr;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = r_rd_ptr;
        ld_out      = 1'b0;
        ld_status   = gbts_pkg::ST_DONE;
        ld_char     = 8'd0;
        case (r_state)
            gbts_pkg::ST_IDLE: begin
                if (in_acc) begin
                    ld_out = !(go_move || go_read);
                    case (i_func)
                        gbts_pkg::FN_INSERT: begin
                            if (full) begin
                                ld_status = gbts_pkg::ST_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = r_cursor;
                                ram_wr_data = i_char_in;
                                n_cursor    = r_cursor + AW'(1);
                                n_length    = r_length + AW'(1);
                            end
                        end
                        gbts_pkg::FN_DEL_BACK: begin
                            if (r_cursor == '0) begin
                                ld_status = gbts_pkg::ST_NO_DELETE;
                            end else begin
                                n_cursor = r_cursor - AW'(1);
                                n_length = r_length - AW'(1);
                            end
                        end
                        gbts_pkg::FN_DEL_FWD: begin
                            if (r_length == r_cursor) begin
                                ld_status = gbts_pkg::ST_NO_DELETE;
                            end else begin
                                n_length = r_length - AW'(1);
                            end
                        end
                        gbts_pkg::FN_READ: begin
                            ram_rd_addr = read_addr_x[AW-1:0];
                            if (pos_x >= len_x) begin
                                ld_status = gbts_pkg::ST_RANGE;
                            end
                        end
                        default: begin
                            ld_status = gbts_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            gbts_pkg::ST_READ: begin
                ld_out  = 1'b1;
                ld_char = ram_rd_data;
            end
            gbts_pkg::ST_MOVE: begin
                // write the byte fetched last cycle while fetching the next
                ram_wr_en = r_pend;
                if (r_remain == '0) begin
                    ld_out   = 1'b1;
                    n_cursor = r_target;
                end
            end
            default: begin
                ld_out = 1'b0;
            end
        endcase
    end

    assign ncur_x = {{(XW-AW){1'b0}}, n_cursor};
    assign nlen_x = {{(XW-AW){1'b0}}, n_length};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gbts_pkg::ST_IDLE;
            r_cursor <= '0;
            r_length <= '0;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_length <= n_length;
            if (ld_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            if (go_move) begin
                r_pend <= 1'b0;
                if (i_func == gbts_pkg::FN_MOVE_LEFT) begin
                    r_remain <= left_steps_x[AW-1:0];
                end else begin
                    r_remain <= right_steps_x[AW-1:0];
                end
            end else if (r_state == gbts_pkg::ST_MOVE) begin
                r_pend <= move_issue;
                if (move_issue) begin
                    r_remain <= r_remain - AW'(1);
                end
            end
        end
    end

    // Payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_ostatus <= ld_status;
            r_ocursor <= ncur_x[11:0];
            r_olength <= nlen_x[11:0];
            r_ochar   <= ld_char;
        end
        if (go_move) begin
            if (i_func == gbts_pkg::FN_MOVE_LEFT) begin
                r_dir_left <= 1'b1;
                r_target   <= left_nc_x[AW-1:0];
                r_rd_ptr   <= cur_dec_x[AW-1:0];
                r_wr_ptr   <= tail_dec_x[AW-1:0];
            end else begin
                r_dir_left <= 1'b0;
                r_target   <= right_nc_x[AW-1:0];
                r_rd_ptr   <= tail_x[AW-1:0];
                r_wr_ptr   <= r_cursor;
            end
        end else if (r_state == gbts_pkg::ST_MOVE) begin
            // advance both pointers towards the far end of the copy
            if (move_issue) begin
                r_rd_ptr <= r_dir_left ? (r_rd_ptr - AW'(1)) : (r_rd_ptr + AW'(1));
            end
            if (r_pend) begin
                r_wr_ptr <= r_dir_left ? (r_wr_ptr - AW'(1)) : (r_wr_ptr + AW'(1));
            end
        end
    end

    gbts_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_text_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_cursor_out  = r_ocursor;
    assign o_text_length = r_olength;
    assign o_char_out    = r_ochar;

    `GBTS_ASSERT_NOW(a_cursor_in_text, i_clk, i_rst_n, 1'b1, r_cursor <= r_length)
    `GBTS_ASSERT_NOW(a_length_fits, i_clk, i_rst_n, 1'b1, len_x < depth_x)
    `GBTS_ASSERT_NOW(a_move_has_work, i_clk, i_rst_n, r_state == gbts_pkg::ST_MOVE,
        (r_remain != '0) || r_pend)
    `GBTS_ASSERT_NEXT(a_read_returns, i_clk, i_rst_n, r_state == gbts_pkg::ST_READ,
        r_ovalid && (r_state == gbts_pkg::ST_IDLE))

endmodule

// ===== rtl/core/gbts_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
